// ===== src/crcdf_pkg.sv =====
// Package with shared constants and the CRC-8 helper of the frame deframer.
`timescale 1ns / 1ps
package crcdf_pkg;
    localparam int unsigned HEADER_BYTES = 7;
    localparam int unsigned FRAME_EXTRA  = 8;
    localparam int unsigned RESULT_LIMIT = 64;
    localparam logic [7:0]  CRC_POLY     = 8'h07;

    typedef enum logic [2:0] {
        CFG_SYNC      = 3'd0,
        CFG_TYPE_CAL  = 3'd1,
        CFG_TYPE_SAVE = 3'd2,
        CFG_TYPE_CLR  = 3'd3,
        CFG_LEN_CAL   = 3'd4,
        CFG_LEN_PLAIN = 3'd5
    } t_cfg_index;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction
endpackage

// ===== src/crcdf_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module crcdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/crc8_frame_deframer.sv =====
// Top level of the sync-byte frame deframer with CRC-8 check.
// Each received byte is written to a circular buffer RAM, then a sequencer rescans it.
// Per byte: accept it, scan buffer bytes for sync, close the scan, read the header type and length,
// run the CRC, compare it, emit each payload byte (waiting on output stalls), then close the frame.
// One request is processed at a time; o_ready is high only while the sequencer is idle.
// Active-low sync reset clears state, counters, fill level and config registers; RAM is not cleared.
`timescale 1ns / 1ps
module crc8_frame_deframer #(
    parameter int BUFFER_DEPTH = 80,
    parameter int PAYLOAD_CAP  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_frame_kind,
    output logic [7:0]  o_payload_value,
    output logic [5:0]  o_payload_index,
    output logic        o_last_of_frame,
    output logic [31:0] o_good_frames,
    output logic [31:0] o_crc_failures,
    output logic [31:0] o_resync_events,
    output logic [31:0] o_bytes_seen,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int FW = $clog2(BUFFER_DEPTH + 1);
    localparam logic [AW:0] DEPTH_W = (AW+1)'(BUFFER_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SCAN_END, S_HDR_TYPE, S_HDR_LEN, S_CRC, S_CMP, S_EMIT, S_EMIT_WAIT
    } t_state;

    t_state      r_state;
    logic        r_ph;
    logic [7:0]  r_sync, r_tcal, r_tsave, r_tclr;
    logic [6:0]  r_lcal, r_lplain;
    logic [AW-1:0] r_head, r_off;
    logic [FW-1:0] r_fill;
    logic        r_skip;
    logic [7:0]  r_kind;
    logic [6:0]  r_len;
    logic [7:0]  r_crc;
    logic [6:0]  r_idx;
    logic [6:0]  r_n;
    logic [31:0] r_ok, r_crcerr, r_resync, r_bytes;
    logic        r_valid;
    logic [7:0]  r_o_kind, r_o_value;
    logic [5:0]  r_o_index;
    logic        r_o_last;
    logic [31:0] r_o_ok, r_o_crcerr, r_o_resync, r_o_bytes;

    logic [7:0]    rd_data;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    logic [FW-1:0] fill_eff, total;
    logic [6:0]    want;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_W) begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    assign fill_eff = (r_fill >= FW'(BUFFER_DEPTH)) ? '0 : r_fill;
    assign wr_en    = (r_state == S_IDLE) && i_valid;
    assign wr_addr  = wrap_add(r_head, fill_eff[AW-1:0]);
    assign rd_addr  = wrap_add(r_head, r_off);
    assign total    = FW'(crcdf_pkg::FRAME_EXTRA) + FW'(r_len);

    always_comb begin
        want = 7'd0;
        if (r_kind == r_tcal) begin
            want = r_lcal;
        end else if (r_kind == r_tsave || r_kind == r_tclr) begin
            want = r_lplain;
        end
        if (want > 7'(PAYLOAD_CAP)) begin
            want = 7'd0;
        end
    end

    crcdf_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_buf (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_rx_byte),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync   <= 8'd170;
            r_tcal   <= 8'd1;
            r_tsave  <= 8'd2;
            r_tclr   <= 8'd3;
            r_lcal   <= 7'd16;
            r_lplain <= 7'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                crcdf_pkg::CFG_SYNC:      r_sync   <= i_cfg_data;
                crcdf_pkg::CFG_TYPE_CAL:  r_tcal   <= i_cfg_data;
                crcdf_pkg::CFG_TYPE_SAVE: r_tsave  <= i_cfg_data;
                crcdf_pkg::CFG_TYPE_CLR:  r_tclr   <= i_cfg_data;
                crcdf_pkg::CFG_LEN_CAL:   r_lcal   <= i_cfg_data[6:0];
                crcdf_pkg::CFG_LEN_PLAIN: r_lplain <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ph     <= 1'b0;
            r_head   <= '0;
            r_off    <= '0;
            r_fill   <= '0;
            r_skip   <= 1'b0;
            r_n      <= '0;
            r_ok     <= '0;
            r_crcerr <= '0;
            r_resync <= '0;
            r_bytes  <= '0;
            r_valid  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_bytes <= r_bytes + 32'd1;
                        if (r_fill >= FW'(BUFFER_DEPTH)) begin
                            r_resync <= r_resync + 32'd1;
                        end
                        r_fill  <= fill_eff + FW'(1);
                        r_n     <= '0;
                        r_skip  <= 1'b0;
                        r_off   <= '0;
                        r_ph    <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!r_ph) begin
                        if (r_fill == '0) begin
                            r_state <= S_SCAN_END;
                        end else begin
                            r_ph <= 1'b1;
                        end
                    end else begin
                        r_ph <= 1'b0;
                        if (rd_data == r_sync) begin
                            r_state <= S_SCAN_END;
                        end else begin
                            r_head <= wrap_add(r_head, AW'(1));
                            r_fill <= r_fill - FW'(1);
                            r_skip <= 1'b1;
                        end
                    end
                end
                S_SCAN_END: begin
                    if (r_skip) begin
                        r_resync <= r_resync + 32'd1;
                    end
                    r_skip <= 1'b0;
                    r_ph   <= 1'b0;
                    if (r_fill < FW'(crcdf_pkg::HEADER_BYTES)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_off   <= AW'(1);
                        r_state <= S_HDR_TYPE;
                    end
                end
                S_HDR_TYPE: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_kind  <= rd_data;
                        r_off   <= AW'(2);
                        r_state <= S_HDR_LEN;
                    end
                end
                S_HDR_LEN: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_len <= rd_data[6:0];
                        if (want == 7'd0 || rd_data != {1'b0, want}) begin
                            r_resync <= r_resync + 32'd1;
                            r_head   <= wrap_add(r_head, AW'(1));
                            r_fill   <= r_fill - FW'(1);
                            r_off    <= '0;
                            r_state  <= S_SCAN;
                        end else if (r_fill < FW'(crcdf_pkg::FRAME_EXTRA) + FW'(want)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_crc   <= 8'h00;
                            r_off   <= AW'(1);
                            r_state <= S_CRC;
                        end
                    end
                end
                S_CRC: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_crc <= crcdf_pkg::crc8_byte(r_crc, rd_data);
                        if (r_off == AW'(6) + AW'(r_len)) begin
                            r_off   <= AW'(7) + AW'(r_len);
                            r_state <= S_CMP;
                        end else begin
                            r_off <= r_off + AW'(1);
                        end
                    end
                end
                S_CMP: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        if (rd_data != r_crc) begin
                            r_crcerr <= r_crcerr + 32'd1;
                            r_head   <= wrap_add(r_head, AW'(1));
                            r_fill   <= r_fill - FW'(1);
                            r_off    <= '0;
                            r_state  <= S_SCAN;
                        end else begin
                            r_ok    <= r_ok + 32'd1;
                            r_off   <= AW'(crcdf_pkg::HEADER_BYTES);
                            r_idx   <= '0;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (r_idx == r_len || r_n >= 7'(crcdf_pkg::RESULT_LIMIT)) begin
                        r_head  <= wrap_add(r_head, total[AW-1:0]);
                        r_fill  <= r_fill - total;
                        r_off   <= '0;
                        r_ph    <= 1'b0;
                        r_state <= S_SCAN;
                    end else begin
                        r_ph <= ~r_ph;
                        if (r_ph) begin
                            r_o_kind   <= r_kind;
                            r_o_value  <= rd_data;
                            r_o_index  <= r_idx[5:0];
                            r_o_last   <= (r_idx + 7'd1 == r_len);
                            r_o_ok     <= r_ok;
                            r_o_crcerr <= r_crcerr;
                            r_o_resync <= r_resync;
                            r_o_bytes  <= r_bytes;
                            r_valid    <= 1'b1;
                            r_state    <= S_EMIT_WAIT;
                        end
                    end
                end
                S_EMIT_WAIT: begin
                    if (i_ready) begin
                        r_valid <= 1'b0;
                        r_n     <= r_n + 7'd1;
                        r_idx   <= r_idx + 7'd1;
                        r_off   <= r_off + AW'(1);
                        r_ph    <= 1'b0;
                        r_state <= S_EMIT;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_valid;
    assign o_frame_kind    = r_o_kind;
    assign o_payload_value = r_o_value;
    assign o_payload_index = r_o_index;
    assign o_last_of_frame = r_o_last;
    assign o_good_frames   = r_o_ok;
    assign o_crc_failures  = r_o_crcerr;
    assign o_resync_events = r_o_resync;
    assign o_bytes_seen    = r_o_bytes;
endmodule

// ===== dv/crc8_frame_deframer_checker.sv =====
// Checker for the frame deframer: predicts payload results from the accepted bytes and compares.
`timescale 1ns / 1ps
module crc8_frame_deframer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [7:0]  o_frame_kind,
    input  logic [7:0]  o_payload_value,
    input  logic [5:0]  o_payload_index,
    input  logic        o_last_of_frame,
    input  logic [31:0] o_good_frames,
    input  logic [31:0] o_crc_failures,
    input  logic [31:0] o_resync_events,
    input  logic [31:0] o_bytes_seen,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_beats_checked,
    output logic [31:0] o_frames_ok,
    output logic [31:0] o_frames_crc_bad,
    output logic [31:0] o_resyncs
);
    localparam int DEPTH = 80;
    localparam int PAYLOAD_MAX = 64;

    typedef struct {
        logic [7:0]  kind;
        logic [7:0]  value;
        logic [5:0]  index;
        logic        last;
        logic [31:0] good;
        logic [31:0] crc_bad;
        logic [31:0] resync;
        logic [31:0] seen;
    } t_payload_beat;

    t_payload_beat expected_beats[$];

    logic [7:0]  sync_reg, kind_cal, kind_save, kind_clear;
    logic [6:0]  len_cal, len_plain;
    logic [7:0]  hold_bytes[DEPTH];
    int          fill;
    logic [31:0] ok_total, crc_total, resync_total, byte_total;

    function automatic int length_for(input logic [7:0] kind);
        int w;
        w = 0;
        if (kind == kind_cal) w = len_cal;
        else if (kind == kind_save || kind == kind_clear) w = len_plain;
        if (w > PAYLOAD_MAX) w = 0;
        return w;
    endfunction

    task automatic drop_front(input int count);
        if (count >= fill) begin
            fill = 0;
        end else begin
            for (int i = 0; i + count < fill; i++) hold_bytes[i] = hold_bytes[i + count];
            fill = fill - count;
        end
    endtask

    function automatic logic [7:0] span_crc(input int count);
        logic [7:0] c;
        c = 8'h00;
        for (int i = 0; i < count; i++) begin
            c = c ^ hold_bytes[1 + i];
            for (int b = 0; b < 8; b++) c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    task automatic deframe_byte(input logic [7:0] rx);
        int skip, want, len, total, n;
        logic [7:0] kind;
        t_payload_beat beat;
        n = 0;
        byte_total++;
        if (fill >= DEPTH) begin
            fill = 0;
            resync_total++;
        end
        hold_bytes[fill] = rx;
        fill++;
        forever begin
            skip = 0;
            while (skip < fill && hold_bytes[skip] != sync_reg) skip++;
            if (skip > 0) begin
                resync_total++;
                drop_front(skip);
            end
            if (fill < crcdf_pkg::HEADER_BYTES) break;
            kind = hold_bytes[1];
            len = hold_bytes[2];
            want = length_for(kind);
            if (want == 0 || len != want) begin
                resync_total++;
                drop_front(1);
                continue;
            end
            total = crcdf_pkg::FRAME_EXTRA + len;
            if (fill < total) break;
            if (hold_bytes[crcdf_pkg::HEADER_BYTES + len] != span_crc(6 + len)) begin
                crc_total++;
                drop_front(1);
                continue;
            end
            ok_total++;
            for (int i = 0; i < len && n < crcdf_pkg::RESULT_LIMIT; i++) begin
                beat.kind = kind;
                beat.value = hold_bytes[crcdf_pkg::HEADER_BYTES + i];
                beat.index = i[5:0];
                beat.last = (i + 1 == len);
                beat.good = ok_total;
                beat.crc_bad = crc_total;
                beat.resync = resync_total;
                beat.seen = byte_total;
                expected_beats.push_back(beat);
                n++;
            end
            drop_front(total);
        end
    endtask

    task automatic check_beat();
        t_payload_beat exp_beat;
        if (expected_beats.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("mismatch: unexpected payload beat kind %0h value %0h index %0d",
                         o_frame_kind, o_payload_value, o_payload_index);
        end else begin
            exp_beat = expected_beats.pop_front();
            o_beats_checked++;
            if (exp_beat.kind !== o_frame_kind || exp_beat.value !== o_payload_value
                || exp_beat.index !== o_payload_index || exp_beat.last !== o_last_of_frame
                || exp_beat.good !== o_good_frames || exp_beat.crc_bad !== o_crc_failures
                || exp_beat.resync !== o_resync_events || exp_beat.seen !== o_bytes_seen) begin
                o_fail_count++;
                if (o_fail_count <= 10) begin
                    $display({"mismatch: expected kind %0h val %0h idx %0d last %0b",
                              " ok %0d crc %0d rs %0d n %0d"},
                             exp_beat.kind, exp_beat.value, exp_beat.index, exp_beat.last,
                             exp_beat.good, exp_beat.crc_bad, exp_beat.resync, exp_beat.seen);
                    $display({"          actual   kind %0h val %0h idx %0d last %0b",
                              " ok %0d crc %0d rs %0d n %0d"},
                             o_frame_kind, o_payload_value, o_payload_index, o_last_of_frame,
                             o_good_frames, o_crc_failures, o_resync_events, o_bytes_seen);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sync_reg = 8'd170;
            kind_cal = 8'd1;
            kind_save = 8'd2;
            kind_clear = 8'd3;
            len_cal = 7'd16;
            len_plain = 7'd1;
            fill = 0;
            ok_total = 0;
            crc_total = 0;
            resync_total = 0;
            byte_total = 0;
            o_fail_count = 0;
            o_beats_checked = 0;
            expected_beats.delete();
        end else begin
            if (i_cfg_we) begin
                case (crcdf_pkg::t_cfg_index'(i_cfg_index))
                    crcdf_pkg::CFG_SYNC:      sync_reg = i_cfg_data;
                    crcdf_pkg::CFG_TYPE_CAL:  kind_cal = i_cfg_data;
                    crcdf_pkg::CFG_TYPE_SAVE: kind_save = i_cfg_data;
                    crcdf_pkg::CFG_TYPE_CLR:  kind_clear = i_cfg_data;
                    crcdf_pkg::CFG_LEN_CAL:   len_cal = i_cfg_data[6:0];
                    crcdf_pkg::CFG_LEN_PLAIN: len_plain = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (o_valid && i_ready) check_beat();
            if (i_valid && o_ready) deframe_byte(i_rx_byte);
        end
        o_pending = expected_beats.size();
        o_frames_ok = ok_total;
        o_frames_crc_bad = crc_total;
        o_resyncs = resync_total;
    end
endmodule

// ===== dv/crc8_frame_deframer_test.sv =====
// Testbench top for the frame deframer: stimulus, flow control, watchdog and verdict.
`timescale 1ns / 1ps
module crc8_frame_deframer_test;
    localparam int IDLE_LIMIT = 50000;
    localparam int SETTLE_CYCLES = 300;

    typedef enum int {FAULT_NONE, FAULT_CRC} t_frame_fault;

    logic        i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready;
    logic [7:0]  i_rx_byte, o_frame_kind, o_payload_value, i_cfg_data;
    logic [5:0]  o_payload_index;
    logic        o_last_of_frame, i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] o_good_frames, o_crc_failures, o_resync_events, o_bytes_seen;
    int          fail_count, pending, beats_checked;
    logic [31:0] frames_ok, frames_crc_bad, resyncs;

    logic [7:0]  cur_sync, cur_cal, cur_save, cur_clear;
    int          cur_len_cal, cur_len_plain;
    int          bytes_sent, hold_trigger, hold_seen;
    int          idle_cycles = 0;

    crc8_frame_deframer i_dut (.*);

    crc8_frame_deframer_checker i_checker (
        .*,
        .o_fail_count(fail_count),
        .o_pending(pending),
        .o_beats_checked(beats_checked),
        .o_frames_ok(frames_ok),
        .o_frames_crc_bad(frames_crc_bad),
        .o_resyncs(resyncs)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int on_len, r, gap;
        i_ready = 1'b0;
        hold_seen = 0;
        forever begin
            if (hold_seen != hold_trigger) begin
                hold_seen = hold_trigger;
                @(negedge i_clk) i_ready <= 1'b0;
                repeat (600) @(negedge i_clk);
            end else begin
                on_len = $urandom_range(1, 24);
                @(negedge i_clk) i_ready <= 1'b1;
                repeat (on_len - 1) @(negedge i_clk);
                r = $urandom_range(0, 9);
                gap = (r < 6) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(30, 90);
                if (gap > 0) begin
                    @(negedge i_clk) i_ready <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
        end
    end

    function automatic logic [7:0] link_crc(input logic [7:0] bytes[$]);
        logic [7:0] c;
        c = 8'h00;
        for (int i = 1; i < bytes.size(); i++) begin
            c = c ^ bytes[i];
            for (int b = 0; b < 8; b++) c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int r, gap;
        r = $urandom_range(0, 19);
        gap = (r < 12) ? 0 : (r < 18) ? $urandom_range(1, 3) : $urandom_range(20, 60);
        if (gap > 0) begin
            @(negedge i_clk) i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_bytes(input logic [7:0] bytes[$]);
        foreach (bytes[i]) send_byte(bytes[i]);
    endtask

    function automatic void build_frame(output logic [7:0] fr[$], input logic [7:0] kind,
                                        input int len, input t_frame_fault fault,
                                        input bit alternate);
        logic [7:0] c;
        fr = {};
        fr.push_back(cur_sync);
        fr.push_back(kind);
        fr.push_back(len[7:0]);
        repeat (4) fr.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < len; i++) fr.push_back(alternate ? ((i % 2) ? 8'hFF : 8'h00)
                                                             : 8'($urandom_range(0, 255)));
        c = link_crc(fr);
        if (fault == FAULT_CRC) c = c ^ (8'h01 << $urandom_range(0, 7));
        fr.push_back(c);
    endfunction

    task automatic send_frame(input logic [7:0] kind, input int len, input t_frame_fault fault);
        logic [7:0] fr[$];
        build_frame(fr, kind, len, fault, 1'b0);
        send_bytes(fr);
    endtask

    task automatic drain();
        @(negedge i_clk) i_valid <= 1'b0;
        while (pending != 0 || !o_ready) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] s, input logic [7:0] tc, input logic [7:0] ts,
                              input logic [7:0] tr, input logic [7:0] lc, input logic [7:0] lp);
        logic [7:0] vals[6];
        vals = '{s, tc, ts, tr, lc, lp};
        for (int i = 0; i < 6; i++) begin
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_index <= 3'(i);
            i_cfg_data <= vals[i];
        end
        @(negedge i_clk) i_cfg_we <= 1'b0;
        cur_sync = s;
        cur_cal = tc;
        cur_save = ts;
        cur_clear = tr;
        cur_len_cal = lc[6:0];
        cur_len_plain = lp[6:0];
    endtask

    task automatic random_phase(input int budget);
        int start, r, pick, len;
        logic [7:0] kind;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            r = $urandom_range(0, 9);
            pick = $urandom_range(0, 2);
            kind = (pick == 0) ? cur_cal : (pick == 1) ? cur_save : cur_clear;
            len = (pick == 0) ? cur_len_cal : cur_len_plain;
            if (len == 0 || len > 64) len = $urandom_range(1, 6);
            if (r < 6) send_frame(kind, len, FAULT_NONE);
            else if (r == 6) send_frame(kind, len, FAULT_CRC);
            else if (r == 7) send_frame(kind, (len % 8) + 1, FAULT_NONE);
            else if (r == 8) send_frame(8'($urandom_range(0, 255)), $urandom_range(1, 6),
                                        FAULT_NONE);
            else repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        logic [7:0] inner[$], outer[$];
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_rx_byte = 8'h00;
        i_cfg_we = 1'b0;
        i_cfg_index = 3'd0;
        i_cfg_data = 8'h00;
        bytes_sent = 0;
        hold_trigger = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        set_config(8'd170, 8'd1, 8'd2, 8'd3, 8'd16, 8'd1);
        send_bytes('{8'h00, 8'hFF, 8'h55});
        build_frame(outer, cur_cal, 16, FAULT_NONE, 1'b1);
        send_bytes(outer);
        send_bytes('{cur_sync, cur_save, 8'd1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_byte(link_crc('{cur_sync, cur_save, 8'd1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}));
        send_frame(cur_clear, 1, FAULT_NONE);
        send_frame(8'h7E, 1, FAULT_NONE);
        send_frame(cur_cal, 15, FAULT_NONE);
        send_frame(cur_save, 1, FAULT_CRC);
        drain();

        // A bad outer frame hides a good frame that ends on the same byte.
        set_config(8'd170, 8'd1, 8'd2, 8'd3, 8'd16, 8'd19);
        build_frame(inner, cur_cal, 16, FAULT_NONE, 1'b0);
        outer = {cur_sync, cur_save, 8'd19};
        foreach (inner[i]) outer.push_back(inner[i]);
        send_bytes(outer);
        drain();

        // Calibrate wins when two type registers match.
        set_config(8'd170, 8'd5, 8'd5, 8'd9, 8'd2, 8'd3);
        send_frame(8'd5, 2, FAULT_NONE);
        send_frame(8'd5, 3, FAULT_NONE);
        send_frame(8'd9, 3, FAULT_NONE);
        drain();

        // Zero and oversized lengths make their types unknown.
        set_config(8'd170, 8'd1, 8'd2, 8'd3, 8'd0, 8'd100);
        send_frame(8'd1, 0, FAULT_NONE);
        send_frame(8'd2, 3, FAULT_NONE);
        drain();

        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(1, 8)), 8'($urandom_range(1, 4)));
        hold_trigger++;
        random_phase(40);
        drain();
        set_config(8'h00, 8'hFF, 8'h00, 8'h7F, 8'd1, 8'd1);
        random_phase(25);
        drain();
        set_config(8'hFF, 8'h80, 8'h7F, 8'h01, 8'd64, 8'd2);
        random_phase(25);
        drain();
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'hFF, 8'($urandom_range(1, 6)));
        random_phase(20);
        drain();

        $display("covered %0d bytes: %0d frames accepted, %0d CRC rejects, %0d resyncs",
                 bytes_sent, frames_ok, frames_crc_bad, resyncs);
        $display("checked %0d payload beats against the prediction", beats_checked);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d beats never arrived", fail_count, pending);
            $display("status: fail");
        end
        $finish;
    end
endmodule
